### hw/rtl/uart_16550_register_block_macros.svh
// Assertion macros for the UART register window.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef UART_16550_REGISTER_BLOCK_MACROS_SVH
`define UART_16550_REGISTER_BLOCK_MACROS_SVH

// same-cycle implication, clocked on clock, off during reset
`define U16550_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define U16550_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/u16550_pkg.sv
// Shared types, constants and helpers of the UART register window.
// No dependencies; used by the top level.
package u16550_pkg;

   localparam int FIFO_DEPTH = 128;
   localparam int AW = $clog2(FIFO_DEPTH);

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_LINE  = 2'd2,
      OP_SLOT  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      REG_DATA  = 3'd0,
      REG_IER   = 3'd1,
      REG_IIR   = 3'd2,
      REG_LCR   = 3'd3,
      REG_MCR   = 3'd4,
      REG_LSR   = 3'd5,
      REG_MSR   = 3'd6,
      REG_SCR   = 3'd7
   } addr_type;

   localparam logic [3:0] IIR_NONE = 4'd1;
   localparam logic [3:0] IIR_THRE = 4'd2;
   localparam logic [3:0] IIR_RDA  = 4'd4;
   localparam logic [3:0] IIR_RLS  = 4'd6;

   localparam logic [7:0] IIR_FIFO_BITS = 8'hC0;

   // mask a character to the word length in LCR bits 1:0
   function automatic logic [7:0] word_mask(input logic [1:0] code);
      logic [7:0] m;
      case (code)
         2'd0:    m = 8'h1F;
         2'd1:    m = 8'h3F;
         2'd2:    m = 8'h7F;
         default: m = 8'hFF;
      endcase
      return m;
   endfunction

   // highest pending source by priority
   function automatic logic [3:0] iir_code(input logic [3:0] ie, input logic ovr,
                                           input logic head_fe, input logic rx_any,
                                           input logic thre);
      logic [3:0] c;
      if (ie[2] && (ovr || head_fe))  c = IIR_RLS;
      else if (ie[0] && rx_any)       c = IIR_RDA;
      else if (ie[1] && thre)         c = IIR_THRE;
      else                            c = IIR_NONE;
      return c;
   endfunction

endpackage

### hw/rtl/u16550_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; read returns the old entry on a same-cycle write.
module u16550_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### hw/rtl/uart_16550_register_block.sv
// UART 16550-style register window: bus access, line receive, transmit slots.
// Path: an accepted request beat passes the read stage (RAM read), then the output register.
// Throughput: one request beat per cycle while req_stall is low; the FIFO RAM reads pipeline behind control state.
// A request is held off only while the read stage is full and the output register is full and stalled.
// Reset (synchronous, active high) clears all control state; FIFO RAM contents stay
// undefined and are never read before written.
`include "uart_16550_register_block_macros.svh"
module uart_16550_register_block (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_opcode,
   input  logic [2:0] req_reg_addr,
   input  logic [7:0] req_write_data,
   input  logic [7:0] req_line_char,
   input  logic       req_line_frame_error,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic       rsp_irq,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_char,
   output logic [1:0] rsp_tx_word_code,
   output logic       rsp_tx_parity_on,
   output logic       rsp_tx_parity_bit,
   output logic       rsp_tx_two_stop
);
   import u16550_pkg::*;

   // control state
   logic [AW-1:0] rx_head_ff, rx_head_in, tx_head_ff, tx_head_in;
   logic [AW:0]   rx_fill_ff, rx_fill_in, tx_fill_ff, tx_fill_in;
   logic [3:0]    ie_ff, ie_in;
   logic [7:0]    lcr_ff, lcr_in;
   logic          fifo_on_ff, fifo_on_in;
   logic [4:0]    mcr_ff, mcr_in;
   logic [7:0]    scr_ff, scr_in;
   logic          ovr_ff, ovr_in;
   logic          thre_ff, thre_in;
   logic          fe_clr_ff, fe_clr_in;
   logic          fe_hold_ff;

   // read stage
   logic          s1_valid_ff;
   logic          s1_rbr_ff, s1_rbr_in;
   logic          s1_tx_ff, s1_tx_in;
   logic [7:0]    s1_rd_ff, s1_rd_in;
   logic          s1_fwd_ff, s1_fwd_in;
   logic          s1_fwd_fe_ff;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_rd_ff, rsp_tc_ff;
   logic          rsp_irq_ff, rsp_tv_ff, rsp_pon_ff, rsp_pb_ff, rsp_ts_ff;
   logic [1:0]    rsp_wc_ff;

   // RAM ports
   logic          rx_wr_en, tx_wr_en;
   logic [AW-1:0] rx_wr_addr, tx_wr_addr;
   logic [8:0]    rx_wr_data;
   logic [8:0]    rx_rd_a, rx_rd_b;
   logic [7:0]    tx_rd;

   logic          accept, out_load;
   logic [AW:0]   cap;
   logic          cur_fe, fe_eff;
   logic [3:0]    code_now;
   op_type        op;
   addr_type      addr;

   logic [7:0]    tc, mask;
   logic          pb;

   assign op       = op_type'(req_opcode);
   assign addr     = addr_type'(req_reg_addr);
   assign out_load = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !out_load;
   assign accept   = req_valid && !req_stall;
   assign cap      = fifo_on_ff ? (AW+1)'(FIFO_DEPTH) : (AW+1)'(1);

   // FE of the head entry: fresh RAM data after a read, else the held copy
   assign cur_fe   = s1_valid_ff ? (s1_fwd_ff ? s1_fwd_fe_ff : rx_rd_b[8]) : fe_hold_ff;
   assign fe_eff   = cur_fe && !fe_clr_ff && (rx_fill_ff != '0);
   assign code_now = iir_code(ie_ff, ovr_ff, fe_eff, rx_fill_ff != '0, thre_ff);

   // next control state for the accepted beat
   always_comb begin
      rx_head_in = rx_head_ff;
      rx_fill_in = rx_fill_ff;
      tx_head_in = tx_head_ff;
      tx_fill_in = tx_fill_ff;
      ie_in      = ie_ff;
      lcr_in     = lcr_ff;
      fifo_on_in = fifo_on_ff;
      mcr_in     = mcr_ff;
      scr_in     = scr_ff;
      ovr_in     = ovr_ff;
      thre_in    = thre_ff;
      fe_clr_in  = fe_clr_ff;
      s1_rbr_in  = 1'b0;
      s1_tx_in   = 1'b0;
      s1_rd_in   = '0;
      rx_wr_en   = 1'b0;
      rx_wr_addr = rx_head_ff + rx_fill_ff[AW-1:0];
      rx_wr_data = {req_line_frame_error, req_line_char};
      tx_wr_en   = 1'b0;
      tx_wr_addr = tx_head_ff + tx_fill_ff[AW-1:0];
      unique case (op)
         OP_READ: begin
            unique case (addr)
               REG_DATA: begin
                  if (rx_fill_ff != '0) begin
                     rx_head_in = rx_head_ff + AW'(1);
                     rx_fill_in = rx_fill_ff - (AW+1)'(1);
                     fe_clr_in  = 1'b0;
                     s1_rbr_in  = 1'b1;
                  end
               end
               REG_IER: s1_rd_in = {4'd0, ie_ff};
               REG_IIR: begin
                  if (code_now == IIR_THRE) thre_in = 1'b0;
                  s1_rd_in = {4'd0, code_now} | (fifo_on_ff ? IIR_FIFO_BITS : 8'd0);
               end
               REG_LCR: s1_rd_in = lcr_ff;
               REG_MCR: s1_rd_in = {3'd0, mcr_ff};
               REG_LSR: begin
                  s1_rd_in = {2'd0, tx_fill_ff == '0, 1'b0, fe_eff, 1'b0, ovr_ff,
                              rx_fill_ff != '0};
                  ovr_in = 1'b0;
                  if (rx_fill_ff != '0) fe_clr_in = 1'b1;
               end
               REG_MSR: s1_rd_in = '0;
               REG_SCR: s1_rd_in = scr_ff;
            endcase
         end
         OP_WRITE: begin
            unique case (addr)
               REG_DATA: begin
                  if (tx_fill_ff < cap) begin
                     tx_wr_en   = 1'b1;
                     tx_fill_in = tx_fill_ff + (AW+1)'(1);
                  end
                  thre_in = 1'b0;
               end
               REG_IER: begin
                  ie_in = req_write_data[3:0];
                  if (req_write_data[1] && tx_fill_ff == '0) thre_in = 1'b1;
               end
               REG_IIR: begin
                  if (req_write_data[0] != fifo_on_ff) begin
                     fifo_on_in = req_write_data[0];
                     rx_head_in = '0;
                     rx_fill_in = '0;
                     tx_head_in = '0;
                     tx_fill_in = '0;
                     thre_in    = 1'b1;
                  end
                  if (req_write_data[1]) begin
                     rx_head_in = '0;
                     rx_fill_in = '0;
                  end
                  if (req_write_data[2]) begin
                     tx_head_in = '0;
                     tx_fill_in = '0;
                     thre_in    = 1'b1;
                  end
               end
               REG_LCR: lcr_in = req_write_data;
               REG_MCR: mcr_in = req_write_data[4:0];
               REG_SCR: scr_in = req_write_data;
               REG_LSR, REG_MSR: ;
            endcase
         end
         OP_LINE: begin
            if (rx_fill_ff < cap) begin
               rx_wr_en   = 1'b1;
               rx_fill_in = rx_fill_ff + (AW+1)'(1);
               if (rx_fill_ff == '0) fe_clr_in = 1'b0;
            end else begin
               ovr_in = 1'b1;
            end
         end
         OP_SLOT: begin
            if (tx_fill_ff != '0) begin
               tx_head_in = tx_head_ff + AW'(1);
               tx_fill_in = tx_fill_ff - (AW+1)'(1);
               if (tx_fill_ff == (AW+1)'(1)) thre_in = 1'b1;
               s1_tx_in = 1'b1;
            end
         end
      endcase
      // forward a push that lands on the new head in the same cycle
      s1_fwd_in = rx_wr_en && (rx_wr_addr == rx_head_in);
   end

   // control registers advance on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_head_ff <= '0;
         rx_fill_ff <= '0;
         tx_head_ff <= '0;
         tx_fill_ff <= '0;
         ie_ff      <= '0;
         lcr_ff     <= '0;
         fifo_on_ff <= 1'b0;
         mcr_ff     <= '0;
         scr_ff     <= '0;
         ovr_ff     <= 1'b0;
         thre_ff    <= 1'b0;
         fe_clr_ff  <= 1'b0;
         fe_hold_ff <= 1'b0;
      end else begin
         fe_hold_ff <= cur_fe;
         if (accept) begin
            rx_head_ff <= rx_head_in;
            rx_fill_ff <= rx_fill_in;
            tx_head_ff <= tx_head_in;
            tx_fill_ff <= tx_fill_in;
            ie_ff      <= ie_in;
            lcr_ff     <= lcr_in;
            fifo_on_ff <= fifo_on_in;
            mcr_ff     <= mcr_in;
            scr_ff     <= scr_in;
            ovr_ff     <= ovr_in;
            thre_ff    <= thre_in;
            fe_clr_ff  <= fe_clr_in;
         end
      end
   end

   // read stage: hold the beat while the RAM data lands
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (out_load) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_rbr_ff    <= s1_rbr_in;
         s1_tx_ff     <= s1_tx_in;
         s1_rd_ff     <= s1_rd_in;
         s1_fwd_ff    <= s1_fwd_in;
         s1_fwd_fe_ff <= req_line_frame_error;
      end
   end

   // receive FIFO: port A pops the head, port B looks ahead at the new head
   u16550_ram #(.WIDTH(9), .DEPTH(FIFO_DEPTH)) u_rx_ram_a (
      .clock   (clock),
      .wr_en   (accept && rx_wr_en),
      .wr_addr (rx_wr_addr),
      .wr_data (rx_wr_data),
      .rd_en   (accept),
      .rd_addr (rx_head_ff),
      .rd_data (rx_rd_a)
   );

   u16550_ram #(.WIDTH(9), .DEPTH(FIFO_DEPTH)) u_rx_ram_b (
      .clock   (clock),
      .wr_en   (accept && rx_wr_en),
      .wr_addr (rx_wr_addr),
      .wr_data (rx_wr_data),
      .rd_en   (accept),
      .rd_addr (rx_head_in),
      .rd_data (rx_rd_b)
   );

   u16550_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_tx_ram (
      .clock   (clock),
      .wr_en   (accept && tx_wr_en),
      .wr_addr (tx_wr_addr),
      .wr_data (req_write_data),
      .rd_en   (accept),
      .rd_addr (tx_head_ff),
      .rd_data (tx_rd)
   );

   // finish the beat: mask characters, form parity
   assign mask = word_mask(lcr_ff[1:0]);
   assign tc   = s1_tx_ff ? (tx_rd & mask) : 8'd0;
   always_comb begin
      if (!lcr_ff[3])     pb = 1'b0;
      else if (lcr_ff[5]) pb = !lcr_ff[4];
      else if (lcr_ff[4]) pb = ^tc;
      else                pb = !(^tc);
   end

   // output register
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_rd_ff  <= s1_rbr_ff ? (rx_rd_a[7:0] & mask) : s1_rd_ff;
         rsp_irq_ff <= code_now != IIR_NONE;
         rsp_tv_ff  <= s1_tx_ff;
         rsp_tc_ff  <= tc;
         rsp_wc_ff  <= s1_tx_ff ? lcr_ff[1:0] : 2'd0;
         rsp_pon_ff <= s1_tx_ff && lcr_ff[3];
         rsp_pb_ff  <= s1_tx_ff && pb;
         rsp_ts_ff  <= s1_tx_ff && lcr_ff[2];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_rd_ff;
   assign rsp_irq           = rsp_irq_ff;
   assign rsp_tx_valid      = rsp_tv_ff;
   assign rsp_tx_char       = rsp_tc_ff;
   assign rsp_tx_word_code  = rsp_wc_ff;
   assign rsp_tx_parity_on  = rsp_pon_ff;
   assign rsp_tx_parity_bit = rsp_pb_ff;
   assign rsp_tx_two_stop   = rsp_ts_ff;

   // checks
   `U16550_ASSERT_NOW(a_rx_cap, 1'b1, rx_fill_ff <= cap, "receive fill beyond capacity")
   `U16550_ASSERT_NOW(a_tx_cap, 1'b1, tx_fill_ff <= cap, "transmit fill beyond capacity")
   `U16550_ASSERT_NEXT(a_s1_load, accept, s1_valid_ff, "accepted beat lost in read stage")

endmodule
